FILE: sv/redd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// redd_pkg
// Shared types, constants and codes of the early drop decision block.
// ----------------------------------------------------------------------------
package redd_pkg;

    localparam int AVG_SCALE_BITS = 10;
    localparam int MAX_IDLE_STEPS = 1024;
    localparam int IDLE_W         = $clog2(MAX_IDLE_STEPS + 1);

    localparam logic [16:0] ONE_FIX     = 17'h10000;
    localparam logic [15:0] LEN_MAX     = 16'hFFFF;
    localparam logic [31:0] ROUND_HALF  = 32'(1) << (AVG_SCALE_BITS - 1);
    localparam logic [31:0] IDLE_LIMIT  = 32'(MAX_IDLE_STEPS);
    localparam logic signed [31:0] PSD_MAX = 32'sh7FFF_FFFF;

    // register reset values
    localparam logic [15:0] RST_MIN_TH   = 16'd5;
    localparam logic [15:0] RST_MAX_TH   = 16'd15;
    localparam logic [16:0] RST_MAX_PROB = 17'd6554;
    localparam logic [4:0]  RST_SHIFT    = 5'd4;
    localparam logic        RST_GENTLE   = 1'b1;
    localparam logic [4:0]  SHIFT_LIMIT  = 5'd16;

    // register indexes
    localparam logic [2:0] REG_MIN_TH   = 3'd0;
    localparam logic [2:0] REG_MAX_TH   = 3'd1;
    localparam logic [2:0] REG_MAX_PROB = 3'd2;
    localparam logic [2:0] REG_SHIFT    = 3'd3;
    localparam logic [2:0] REG_GENTLE   = 3'd4;

    // decision causes
    localparam logic [1:0] CAUSE_BELOW  = 2'd0;
    localparam logic [1:0] CAUSE_PASS   = 2'd1;
    localparam logic [1:0] CAUSE_FORCED = 2'd2;
    localparam logic [1:0] CAUSE_RANDOM = 2'd3;

    // divider operand selects
    localparam logic [1:0] DIV_LSLOPE = 2'd0;
    localparam logic [1:0] DIV_LOFF   = 2'd1;
    localparam logic [1:0] DIV_GSLOPE = 2'd2;
    localparam logic [1:0] DIV_TARGET = 2'd3;

    typedef struct packed {
        logic [15:0] queue_length;
        logic [31:0] tick_now;
        logic [15:0] random_bits;
    } in_item_t;

    typedef struct packed {
        logic        drop;
        logic [1:0]  drop_cause;
        logic [15:0] average_length;
    } out_item_t;

    typedef struct packed {
        logic       cfg_wr;
        logic       load_in;
        logic       prep;
        logic       ewma_step;
        logic       prob_avg;
        logic       prob_mul;
        logic       prob_sub;
        logic       div_start;
        logic       div_store;
        logic [1:0] div_sel;
        logic       derive_fin;
        logic       commit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic ewma_busy;
        logic need_div;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

FILE: sv/redd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// redd_div
// Restoring divider, 32-bit dividend by 17-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module redd_div import redd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] num,
    input  wire logic [16:0] den,
    output logic             done,
    output logic [31:0]      quo
);

    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] rem_reg;
    logic [16:0] den_reg;
    logic [31:0] quo_reg;
    logic [17:0] shifted;
    logic        fits;

    assign shifted = {rem_reg, quo_reg[31]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= 6'd32;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end else if (busy_reg) begin
            rem_reg <= fits ? 17'(shifted - {1'b0, den_reg}) : shifted[16:0];
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

FILE: sv/redd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// redd_datapath
// Configuration, derived coefficients, average, drop count and result register.
// ----------------------------------------------------------------------------
module redd_datapath import redd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire in_item_t    s_data,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data,
    input  wire cmd_t        cmd,
    output status_t          status,
    input  wire logic        m_ready,
    output logic             m_valid,
    output out_item_t        m_data
);

    // configuration
    logic [15:0] min_th_reg, max_th_reg;
    logic [16:0] mp_reg;
    logic [4:0]  ash_reg;
    logic        gentle_reg;
    // derived
    logic [16:0] lslope_reg, gslope_reg, kill_reg;
    logic [31:0] loff_reg;
    logic [17:0] goff_reg;
    // persistent state
    logic [31:0] avg_sc_reg;
    logic signed [31:0] psd_reg;
    logic [15:0] rtarget_reg;
    logic [31:0] last_tick_reg;
    // per transaction
    logic [15:0] q_reg, rnd_reg, avg_len_reg, quot_reg;
    logic [31:0] tick_reg;
    logic [IDLE_W-1:0] n_reg;
    logic        sh0_reg, below_reg, kill_hit_reg, lin_reg;
    logic [48:0] prod_reg;
    logic signed [40:0] p_reg;
    logic signed [31:0] psd_inc_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    // divider
    logic [31:0] div_num, div_quo;
    logic [16:0] div_den;
    logic        div_done;

    logic [15:0] diff_th;
    logic        lo_ge_hi;
    logic [31:0] mp_lo;
    logic [16:0] p_clamp;

    assign diff_th  = max_th_reg - min_th_reg;
    assign lo_ge_hi = min_th_reg >= max_th_reg;
    assign mp_lo    = {15'b0, mp_reg} * {16'b0, min_th_reg};
    assign p_clamp  = (p_reg > 41'sd65536) ? ONE_FIX : p_reg[16:0];

    always_comb begin
        case (cmd.div_sel)
            DIV_LSLOPE: begin
                div_num = {15'b0, mp_reg};
                div_den = {1'b0, diff_th};
            end
            DIV_LOFF: begin
                div_num = mp_lo;
                div_den = {1'b0, diff_th};
            end
            DIV_GSLOPE: begin
                div_num = {15'b0, 17'(ONE_FIX - mp_reg)};
                div_den = (max_th_reg == 16'd0) ? 17'd1 : {1'b0, max_th_reg};
            end
            default: begin
                div_num = {16'b0, rtarget_reg};
                div_den = p_clamp;
            end
        endcase
    end

    redd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // one averaging sample toward q_reg (zero on the idle path)
    logic [33:0] ew_target, ew_a, ew_up, ew_dn;
    logic [31:0] avg_step_next;

    assign ew_target = 34'({q_reg, {AVG_SCALE_BITS{1'b0}}});
    assign ew_a      = {2'b0, avg_sc_reg};
    assign ew_up     = (ew_target - ew_a) >> ash_reg;
    assign ew_dn     = (ew_a - ew_target + (34'(1) << ash_reg) - 34'd1) >> ash_reg;
    assign avg_step_next = (ew_target >= ew_a) ? 32'(ew_a + ew_up) : 32'(ew_a - ew_dn);

    // idle sample count
    logic [31:0] idle_raw;
    logic [IDLE_W-1:0] idle_n_next;

    assign idle_raw    = (last_tick_reg == 32'd0) ? 32'd1 : tick_reg - last_tick_reg;
    assign idle_n_next = (idle_raw > IDLE_LIMIT) ? IDLE_W'(MAX_IDLE_STEPS)
                                                 : idle_raw[IDLE_W-1:0];

    // unscaled average
    logic [32:0] rnd_sum, unscaled;
    logic [15:0] avg_len_next;

    assign rnd_sum      = {1'b0, avg_sc_reg} + {1'b0, ROUND_HALF};
    assign unscaled     = rnd_sum >> AVG_SCALE_BITS;
    assign avg_len_next = sh0_reg ? q_reg
                        : ((|unscaled[32:16]) ? LEN_MAX : unscaled[15:0]);

    logic        lin_next;
    logic [48:0] prod_next;
    logic signed [40:0] p_next;
    logic signed [31:0] psd_inc_next;

    assign lin_next     = avg_len_reg <= max_th_reg;
    assign prod_next    = (lin_next ? lslope_reg : gslope_reg) * avg_sc_reg;
    assign p_next       = $signed({2'b0, prod_reg[48:AVG_SCALE_BITS]})
                        - (lin_reg ? $signed({9'b0, loff_reg})
                                   : $signed({{23{goff_reg[17]}}, goff_reg}));
    assign psd_inc_next = (psd_reg == PSD_MAX) ? psd_reg : psd_reg + 32'sd1;

    logic in_band, rand_drop;
    assign in_band   = !below_reg && !kill_hit_reg;
    assign rand_drop = status.need_div && (psd_inc_reg > $signed({16'b0, quot_reg}));

    always_comb begin
        status.div_done  = div_done;
        status.ewma_busy = (n_reg != '0) && ((avg_sc_reg != 32'd0) || (q_reg != 16'd0));
        status.need_div  = in_band && (psd_inc_reg > 32'sd0) && (p_reg > 41'sd0);
        status.out_free  = !m_valid_reg || m_ready;
    end

    // control and persistent state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_th_reg    <= RST_MIN_TH;
            max_th_reg    <= RST_MAX_TH;
            mp_reg        <= RST_MAX_PROB;
            ash_reg       <= RST_SHIFT;
            gentle_reg    <= RST_GENTLE;
            avg_sc_reg    <= '0;
            psd_reg       <= -32'sd1;
            rtarget_reg   <= '0;
            last_tick_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.cfg_wr) begin
                case (cfg_index)
                    REG_MIN_TH:   min_th_reg <= cfg_data[15:0];
                    REG_MAX_TH:   max_th_reg <= cfg_data[15:0];
                    REG_MAX_PROB: mp_reg <= (cfg_data > ONE_FIX) ? ONE_FIX : cfg_data;
                    REG_SHIFT:    ash_reg <= (cfg_data[4:0] > SHIFT_LIMIT) ? SHIFT_LIMIT
                                                                        : cfg_data[4:0];
                    REG_GENTLE:   gentle_reg <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (cmd.prep) begin
                if (ash_reg == 5'd0) begin
                    avg_sc_reg <= 32'({q_reg, {AVG_SCALE_BITS{1'b0}}});
                end else if (q_reg != 16'd0) begin
                    last_tick_reg <= '0;
                end else begin
                    last_tick_reg <= tick_reg;
                end
            end
            if (cmd.ewma_step) begin
                avg_sc_reg <= avg_step_next;
            end
            if (cmd.commit) begin
                if (below_reg || kill_hit_reg) begin
                    psd_reg <= -32'sd1;
                end else if (rand_drop) begin
                    psd_reg     <= 32'sd0;
                    rtarget_reg <= rnd_reg;
                end else begin
                    psd_reg <= psd_inc_reg;
                    if (psd_inc_reg == 32'sd0) begin
                        rtarget_reg <= rnd_reg;
                    end
                end
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            q_reg    <= s_data.queue_length;
            tick_reg <= s_data.tick_now;
            rnd_reg  <= s_data.random_bits;
        end
        if (cmd.prep) begin
            sh0_reg <= ash_reg == 5'd0;
            if (ash_reg == 5'd0) begin
                n_reg <= '0;
            end else if (q_reg != 16'd0) begin
                n_reg <= IDLE_W'(1);
            end else begin
                n_reg <= idle_n_next;
            end
        end
        if (cmd.ewma_step) begin
            n_reg <= n_reg - IDLE_W'(1);
        end
        if (cmd.prob_avg) begin
            avg_len_reg <= avg_len_next;
        end
        if (cmd.prob_mul) begin
            lin_reg      <= lin_next;
            prod_reg     <= prod_next;
            below_reg    <= avg_len_reg <= min_th_reg;
            kill_hit_reg <= {1'b0, avg_len_reg} > kill_reg;
        end
        if (cmd.prob_sub) begin
            p_reg       <= p_next;
            psd_inc_reg <= psd_inc_next;
        end
        if (cmd.div_store) begin
            case (cmd.div_sel)
                DIV_LSLOPE: lslope_reg <= div_quo[16:0];
                DIV_LOFF:   loff_reg   <= div_quo;
                DIV_GSLOPE: gslope_reg <= div_quo[16:0];
                default:    quot_reg   <= div_quo[15:0];
            endcase
        end
        if (cmd.derive_fin) begin
            goff_reg <= 18'h10000 - {mp_reg, 1'b0};
            kill_reg <= (gentle_reg && (mp_reg != ONE_FIX)) ? {max_th_reg, 1'b0}
                                                            : {1'b0, max_th_reg};
            if (lo_ge_hi) begin
                lslope_reg <= '0;
                loff_reg   <= 32'd1;
            end
        end
        if (cmd.commit) begin
            m_data_reg.average_length <= avg_len_reg;
            if (below_reg) begin
                m_data_reg.drop       <= 1'b0;
                m_data_reg.drop_cause <= CAUSE_BELOW;
            end else if (kill_hit_reg) begin
                m_data_reg.drop       <= 1'b1;
                m_data_reg.drop_cause <= CAUSE_FORCED;
            end else if (rand_drop) begin
                m_data_reg.drop       <= 1'b1;
                m_data_reg.drop_cause <= CAUSE_RANDOM;
            end else begin
                m_data_reg.drop       <= 1'b0;
                m_data_reg.drop_cause <= CAUSE_PASS;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

FILE: sv/redd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// redd_ctrl
// Sequencer for coefficient derivation and the per-packet decision steps.
// ----------------------------------------------------------------------------
module redd_ctrl import redd_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire logic    cfg_valid,
    output logic         cfg_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [4:0] ST_D_LS  = 5'd0;
    localparam logic [4:0] ST_D_LSW = 5'd1;
    localparam logic [4:0] ST_D_LO  = 5'd2;
    localparam logic [4:0] ST_D_LOW = 5'd3;
    localparam logic [4:0] ST_D_GS  = 5'd4;
    localparam logic [4:0] ST_D_GSW = 5'd5;
    localparam logic [4:0] ST_D_FIN = 5'd6;
    localparam logic [4:0] ST_IDLE  = 5'd7;
    localparam logic [4:0] ST_PREP  = 5'd8;
    localparam logic [4:0] ST_EWMA  = 5'd9;
    localparam logic [4:0] ST_P1    = 5'd10;
    localparam logic [4:0] ST_P2    = 5'd11;
    localparam logic [4:0] ST_P3    = 5'd12;
    localparam logic [4:0] ST_DEC   = 5'd13;
    localparam logic [4:0] ST_DIVW  = 5'd14;
    localparam logic [4:0] ST_FIN   = 5'd15;

    logic [4:0] state_reg, state_next;

    assign cfg_ready = state_reg == ST_IDLE;
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_D_LS: begin
                cmd.div_sel   = DIV_LSLOPE;
                cmd.div_start = 1'b1;
                state_next    = ST_D_LSW;
            end
            ST_D_LSW: begin
                cmd.div_sel = DIV_LSLOPE;
                if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_D_LO;
                end
            end
            ST_D_LO: begin
                cmd.div_sel   = DIV_LOFF;
                cmd.div_start = 1'b1;
                state_next    = ST_D_LOW;
            end
            ST_D_LOW: begin
                cmd.div_sel = DIV_LOFF;
                if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_D_GS;
                end
            end
            ST_D_GS: begin
                cmd.div_sel   = DIV_GSLOPE;
                cmd.div_start = 1'b1;
                state_next    = ST_D_GSW;
            end
            ST_D_GSW: begin
                cmd.div_sel = DIV_GSLOPE;
                if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_D_FIN;
                end
            end
            ST_D_FIN: begin
                cmd.derive_fin = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_IDLE: begin
                if (cfg_valid) begin
                    cmd.cfg_wr = 1'b1;
                    state_next = ST_D_LS;
                end else if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_EWMA;
            end
            ST_EWMA: begin
                // one decay sample per cycle until the count or the average runs out
                if (status.ewma_busy) begin
                    cmd.ewma_step = 1'b1;
                end else begin
                    state_next = ST_P1;
                end
            end
            ST_P1: begin
                cmd.prob_avg = 1'b1;
                state_next   = ST_P2;
            end
            ST_P2: begin
                cmd.prob_mul = 1'b1;
                state_next   = ST_P3;
            end
            ST_P3: begin
                cmd.prob_sub = 1'b1;
                state_next   = ST_DEC;
            end
            ST_DEC: begin
                cmd.div_sel = DIV_TARGET;
                if (status.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVW;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DIVW: begin
                cmd.div_sel = DIV_TARGET;
                if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.div_sel = DIV_TARGET;
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_D_LS;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/red_early_drop_decision.sv
`default_nettype none
// ----------------------------------------------------------------------------
// red_early_drop_decision
// Random early detection drop decision with gentle ramp, one result per packet.
// ----------------------------------------------------------------------------
// A packet runs through preparation, the averaging samples, the average,
// product and subtraction steps and the decision; when the drop count must be
// compared against target / probability, the serial divider runs before the
// result is committed. On an empty queue the average takes one decay sample
// per idle tick (up to 1024, fewer once the average reaches zero). The next packet
// is accepted as soon as the result is in the output register. After reset and
// after every register write the block derives slopes and offsets through the
// same divider and accepts no packet in that time.
module red_early_drop_decision import redd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    redd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    redd_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

FILE: sv/redd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// redd_checker
// Port-level checks of the early drop decision block.
// ----------------------------------------------------------------------------
module redd_checker import redd_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data,
    input wire logic      cfg_valid,
    input wire logic      cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // drop flag agrees with the cause
    a_drop_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.drop == ((m_data.drop_cause == CAUSE_FORCED) ||
                                     (m_data.drop_cause == CAUSE_RANDOM))))
        else $error("drop flag does not match cause");

    // one packet in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !cfg_ready)
        else $error("accepted while a packet is in work");

    // a register write triggers coefficient derivation
    a_cfg_derive: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_ready && !cfg_ready)
        else $error("ready during derivation");

endmodule

bind red_early_drop_decision redd_checker u_redd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
`default_nettype wire

FILE: verif/red_early_drop_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// red_early_drop_checker
// Watches the packet, result and register channels of the early drop block,
// predicts each decision and compares it with what the block returns.
// ----------------------------------------------------------------------------
module red_early_drop_checker import redd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire in_item_t    s_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire out_item_t   m_data,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               cause_seen [4]
);

    logic [15:0] min_th, max_th;
    logic [16:0] max_prob;
    logic [4:0]  avg_shift;
    logic        gentle;

    logic [31:0]        avg_scaled;
    logic signed [31:0] since_drop;
    logic [15:0]        rnd_target;
    logic [31:0]        idle_tick;
    logic [31:0]        lin_slope, lin_off, gen_slope, kill;
    logic signed [31:0] gen_off;

    out_item_t decisions_due[$];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic void rederive();
        logic [31:0] d;
        if (min_th >= max_th) begin
            lin_slope = 0;
            lin_off   = 1;
        end else begin
            d = max_th - min_th;
            lin_slope = max_prob / d;
            lin_off   = 32'((64'(max_prob) * min_th) / d);
        end
        gen_slope = (32'(ONE_FIX) - max_prob) / (max_th != 0 ? 32'(max_th) : 32'd1);
        gen_off   = 32'sh10000 - 2 * $signed({15'd0, max_prob});
        kill      = (gentle && max_prob != ONE_FIX) ? 2 * 32'(max_th) : 32'(max_th);
    endfunction

    function automatic void ewma(input logic [31:0] v);
        logic [63:0] tgt, a;
        tgt = 64'(v) << AVG_SCALE_BITS;
        a = 64'(avg_scaled);
        if (tgt >= a)
            a = a + ((tgt - a) >> avg_shift);
        else
            a = a - ((a - tgt + ((64'd1 << avg_shift) - 1)) >> avg_shift);
        avg_scaled = a[31:0];
    endfunction

    function automatic logic [15:0] rounded_avg();
        logic [63:0] u;
        u = (64'(avg_scaled) + 64'(ROUND_HALF)) >> AVG_SCALE_BITS;
        return u > 64'hFFFF ? 16'hFFFF : u[15:0];
    endfunction

    function automatic out_item_t decide(input in_item_t pkt);
        out_item_t r;
        logic [31:0] avg, n;
        longint p;
        r = '0;
        if (avg_shift == 0) begin
            avg_scaled = 32'(pkt.queue_length) << AVG_SCALE_BITS;
            avg = pkt.queue_length;
        end else if (pkt.queue_length != 0) begin
            ewma(32'(pkt.queue_length));
            idle_tick = 0;
            avg = rounded_avg();
        end else begin
            n = idle_tick != 0 ? pkt.tick_now - idle_tick : 32'd1;
            if (n > IDLE_LIMIT)
                n = IDLE_LIMIT;
            for (int i = 0; i < n && avg_scaled != 0; i++)
                ewma(0);
            idle_tick = pkt.tick_now;
            avg = rounded_avg();
        end
        if (avg <= min_th) begin
            since_drop = -1;
            r.drop_cause = CAUSE_BELOW;
        end else if (avg > kill) begin
            since_drop = -1;
            r.drop = 1'b1;
            r.drop_cause = CAUSE_FORCED;
        end else begin
            if (avg <= max_th)
                p = longint'((64'(lin_slope) * avg_scaled) >> AVG_SCALE_BITS) - longint'(lin_off);
            else
                p = longint'((64'(gen_slope) * avg_scaled) >> AVG_SCALE_BITS) - longint'(gen_off);
            if (since_drop < PSD_MAX)
                since_drop++;
            if (since_drop > 0 && p > 0 && longint'(since_drop) > longint'(rnd_target) / p) begin
                since_drop = 0;
                rnd_target = pkt.random_bits;
                r.drop = 1'b1;
                r.drop_cause = CAUSE_RANDOM;
            end else begin
                if (since_drop == 0)
                    rnd_target = pkt.random_bits;
                r.drop_cause = CAUSE_PASS;
            end
        end
        r.average_length = avg[15:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            min_th = RST_MIN_TH;
            max_th = RST_MAX_TH;
            max_prob = RST_MAX_PROB;
            avg_shift = RST_SHIFT;
            gentle = RST_GENTLE;
            avg_scaled = 0;
            since_drop = -1;
            rnd_target = 0;
            idle_tick = 0;
            rederive();
            decisions_due.delete();
            fail_count = 0;
            pending = 0;
            for (int i = 0; i < 4; i++)
                cause_seen[i] = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_TH:   min_th = cfg_data[15:0];
                    REG_MAX_TH:   max_th = cfg_data[15:0];
                    REG_MAX_PROB: max_prob = cfg_data > ONE_FIX ? ONE_FIX : cfg_data;
                    REG_SHIFT:    avg_shift = cfg_data[4:0] > SHIFT_LIMIT ? SHIFT_LIMIT
                                                                          : cfg_data[4:0];
                    REG_GENTLE:   gentle = cfg_data[0];
                    default: ;
                endcase
                rederive();
            end
            if (s_valid && s_ready)
                decisions_due = {decisions_due, decide(s_data)};
            if (m_valid && m_ready) begin
                if (decisions_due.size() == 0) begin
                    report_mismatch("results outstanding", 1, 0);
                end else begin
                    want = decisions_due.pop_front();
                    cause_seen[m_data.drop_cause]++;
                    if (m_data.drop !== want.drop)
                        report_mismatch("drop", m_data.drop, want.drop);
                    if (m_data.drop_cause !== want.drop_cause)
                        report_mismatch("drop_cause", m_data.drop_cause, want.drop_cause);
                    if (m_data.average_length !== want.average_length)
                        report_mismatch("average_length", m_data.average_length,
                                        want.average_length);
                end
            end
            pending = decisions_due.size();
        end
    end

endmodule

FILE: verif/tb_red_early_drop_decision.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_red_early_drop_decision
// Drives packets and register writes into the early drop block across
// threshold, averaging and gentle settings; a checker predicts every decision.
// ----------------------------------------------------------------------------
module tb_red_early_drop_decision;
    import redd_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;

    int  fail_count, pending, cause_seen [4];
    bit  stall_on = 1'b1;
    int  packets_sent = 0;
    int  stall_left = 0;
    logic [31:0] tick_clock = 32'd1;

    initial begin
        forever #1 aclk = ~aclk;
    end

    red_early_drop_decision i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    red_early_drop_checker i_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .fail_count, .pending, .cause_seen
    );

    // result side stalls in random bursts while stall_on is set
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_on && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(posedge aclk);
        repeat (1100) @(posedge aclk);
    endtask

    task automatic send_packet(input logic [15:0] qlen, input logic [31:0] tk,
                               input logic [15:0] rnd);
        if (stall_on && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        s_data  <= '{queue_length: qlen, tick_now: tk, random_bits: rnd};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
        packets_sent++;
        @(posedge aclk);
    endtask

    // random packet: mostly a wandering queue with advancing ticks
    task automatic random_packet(inout logic [15:0] qlevel, input int span);
        int r;
        logic [31:0] tk;
        r = $urandom_range(0, 99);
        if (r < 15)
            qlevel = 0;
        else if (r < 20)
            qlevel = 16'($urandom);
        else
            qlevel = 16'(int'($urandom_range(0, span)));
        tick_clock = tick_clock + $urandom_range(0, 40);
        tk = ($urandom_range(0, 30) == 0) ? 32'($urandom) : tick_clock;
        if ($urandom_range(0, 50) == 0)
            tk = 32'd0;
        send_packet(qlevel, tk, 16'($urandom));
    endtask

    initial begin
        logic [15:0] qlevel;
        logic [16:0] probs [6];
        int span;
        probs = '{17'd0, 17'd6554, 17'd32768, 17'd65535, 17'd65536, 17'h1FFFF};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, idle decay, forced and random drops
        send_packet(16'd0, 32'd0, 16'd0);
        send_packet(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_packet(16'hFFFF, 32'd7, 16'h0000);
        send_packet(16'd0, 32'd100, 16'd1);
        send_packet(16'd0, 32'd3000, 16'd2);
        send_packet(16'd0, 32'd2990, 16'd3);
        for (int i = 0; i < 8; i++)
            send_packet(16'd12, 32'd0, 16'(i * 7));
        for (int i = 0; i < 6; i++)
            send_packet(16'd25, 32'd0, 16'(i));
        send_packet(16'd40, 32'd0, 16'hAAAA);
        send_packet(16'd0, 32'd1, 16'h5555);
        wait_drained();

        // pinned settings: shift zero, crossed thresholds, zero max, out of range
        write_reg(REG_SHIFT, 17'd0);
        write_reg(REG_MAX_PROB, 17'h1FFFF);
        send_packet(16'd9, 32'd5, 16'd0);
        send_packet(16'd20, 32'd5, 16'd0);
        send_packet(16'd31, 32'd5, 16'd0);
        wait_drained();
        write_reg(REG_SHIFT, 17'h1F);
        write_reg(REG_MIN_TH, 17'd20);
        write_reg(REG_MAX_TH, 17'd0);
        write_reg(REG_GENTLE, 17'd0);
        write_reg(3'd7, 17'h1ABCD);
        send_packet(16'd30, 32'd9, 16'd4);
        send_packet(16'd0, 32'd9, 16'd4);
        wait_drained();

        // random phases over many settings
        for (int ph = 0; ph < 20; ph++) begin
            write_reg(REG_SHIFT, 17'(ph == 0 ? 0 : ph == 1 ? 16 : $urandom_range(0, 31)));
            write_reg(REG_MIN_TH, 17'(ph == 2 ? 0 : ph == 3 ? 65535 : $urandom_range(0, 40)));
            write_reg(REG_MAX_TH, 17'(ph == 4 ? 0 : ph == 3 ? 65535
                                                        : $urandom_range(10, 90)));
            write_reg(REG_MAX_PROB, ph < 6 ? probs[ph] : 17'($urandom_range(0, 70000)));
            write_reg(REG_GENTLE, 17'($urandom_range(0, 1)));
            if (ph >= 17)
                stall_on = 1'b0;
            span = (ph % 4 == 0) ? 200 : 100;
            qlevel = 0;
            for (int i = 0; i < 100; i++)
                random_packet(qlevel, span);
            wait_drained();
        end

        $display("tb: %0d packets; causes below/pass/forced/random = %0d/%0d/%0d/%0d",
                 packets_sent, cause_seen[0], cause_seen[1], cause_seen[2], cause_seen[3]);
        $display("tb: 22 register settings including shift 0/16, crossed and zero thresholds");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
